// File: rtl/lbh_pkg.sv
package lbh_pkg;

    // sizing
    localparam int MAX_BINS    = 30;
    localparam int SLOT_COUNT  = MAX_BINS + 2;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int DATA_W      = 32;
    localparam int WIDTH_W     = 31;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MIN   = 2'd0,
        REG_RANGE_MAX   = 2'd1,
        REG_BIN_WIDTH   = 2'd2,
        REG_BINS_IN_USE = 2'd3
    } t_cfg_reg;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic classify;
        logic div_step;
        logic fix_slot;
        logic ram_rd;
        logic ram_wr;
        logic ro_rd;
        logic ro_load;
        logic clear_all;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic bypass;
        logic div_last;
        logic item_last;
        logic ro_end;
        logic out_hold;
    } t_dp_status;

endpackage

// File: rtl/lbh_ram.sv
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lbh_datapath.sv
module lbh_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [lbh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lbh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input item
    input  logic [lbh_pkg::DATA_W-1:0]       i_sample,
    input  logic                             i_last_sample,
    // controller link
    input  lbh_pkg::t_dp_cmd                 i_cmd,
    output lbh_pkg::t_dp_status              o_status,
    // result beat
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lbh_pkg::SLOT_W-1:0]       o_bin_index,
    output logic [lbh_pkg::CNT_W-1:0]        o_bin_count,
    output logic                             o_last_bin
);

    import lbh_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0]  r_range_min;
    logic signed [DATA_W-1:0]  r_range_max;
    logic [WIDTH_W-1:0]        r_bin_width;
    logic [SLOT_W-1:0]         r_bins_in_use;

    // item registers
    logic signed [DATA_W-1:0]  r_x;
    logic                      r_last;
    logic [SLOT_W-1:0]         r_nb;
    logic [WIDTH_W-1:0]        r_w;
    logic [SLOT_W-1:0]         r_slot;

    // divider
    logic [DATA_W-1:0]         r_dvd;
    logic [WIDTH_W-1:0]        r_rem;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic [WIDTH_W:0]          trial;
    logic                      trial_ok;

    // counter store
    logic [SLOT_COUNT-1:0]     r_valid;
    logic                      r_rd_valid;
    logic [SLOT_W-1:0]         r_k;
    logic                      ram_re;
    logic [SLOT_W-1:0]         ram_raddr;
    logic [CNT_W-1:0]          ram_rdata;
    logic [CNT_W-1:0]          cur_count;
    logic [CNT_W-1:0]          next_count;

    // output register
    logic                      r_out_valid;
    logic [SLOT_W-1:0]         r_out_index;
    logic [CNT_W-1:0]          r_out_count;
    logic                      r_out_last;

    logic                      under;
    logic                      over;
    logic [SLOT_W-1:0]         n_nb;
    logic [SLOT_W-1:0]         nb_plus1;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= DATA_W'(0);
            r_range_max   <= DATA_W'(2097152);
            r_bin_width   <= WIDTH_W'(65536);
            r_bins_in_use <= SLOT_W'(MAX_BINS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_RANGE_MIN:   r_range_min   <= i_cfg_data[DATA_W-1:0];
                REG_RANGE_MAX:   r_range_max   <= i_cfg_data[DATA_W-1:0];
                REG_BIN_WIDTH:   r_bin_width   <= i_cfg_data[WIDTH_W-1:0];
                REG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // bins actually in use, clamped to one..MAX_BINS
    always_comb begin
        priority if (r_bins_in_use == '0) begin
            n_nb = SLOT_W'(1);
        end else if (r_bins_in_use > SLOT_W'(MAX_BINS)) begin
            n_nb = SLOT_W'(MAX_BINS);
        end else begin
            n_nb = r_bins_in_use;
        end
    end

    assign nb_plus1 = r_nb + SLOT_W'(1);
    assign under    = (r_x <= r_range_min);
    assign over     = (r_x >= r_range_max);

    // one restoring division step
    assign trial    = {r_rem, r_dvd[DATA_W-1]};
    assign trial_ok = (trial >= {1'b0, r_w});

    // item capture, classification and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x    <= i_sample;
            r_last <= i_last_sample;
            r_nb   <= n_nb;
            r_w    <= (r_bin_width == '0) ? WIDTH_W'(1) : r_bin_width;
        end
        if (i_cmd.classify) begin
            r_slot    <= under ? '0 : nb_plus1;
            r_dvd     <= DATA_W'(r_x - r_range_min);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= trial_ok ? WIDTH_W'(trial - {1'b0, r_w}) : trial[WIDTH_W-1:0];
            r_dvd     <= {r_dvd[DATA_W-2:0], trial_ok};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        // quotient beyond the bins lands in the last regular bin
        if (i_cmd.fix_slot) begin
            r_slot <= (r_dvd >= DATA_W'(r_nb)) ? r_nb
                                               : r_dvd[SLOT_W-1:0] + SLOT_W'(1);
        end
    end

    // counter store access
    assign ram_re    = i_cmd.ram_rd | i_cmd.ro_rd;
    assign ram_raddr = i_cmd.ram_rd ? r_slot : r_k;
    assign cur_count = r_rd_valid ? ram_rdata : '0;
    assign next_count = (cur_count == '1) ? cur_count : cur_count + CNT_W'(1);

    lbh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOT_COUNT)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_wr),
        .i_waddr (r_slot),
        .i_wdata (next_count),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // valid bits stand for the cleared state of each counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.ram_wr) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_valid <= r_valid[ram_raddr];
        end
    end

    // readout index
    always_ff @(posedge i_clk) begin
        if (i_cmd.ram_wr) begin
            r_k <= '0;
        end else if (i_cmd.ro_load) begin
            r_k <= r_k + SLOT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ro_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ro_load) begin
            r_out_index <= r_k;
            r_out_count <= cur_count;
            r_out_last  <= (r_k == nb_plus1);
        end
    end

    assign o_status.bypass    = under | over;
    assign o_status.div_last  = (r_div_cnt == '1);
    assign o_status.item_last = r_last;
    assign o_status.ro_end    = (r_k == nb_plus1);
    assign o_status.out_hold  = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_index;
    assign o_bin_count = r_out_count;
    assign o_last_bin  = r_out_last;

    // a held beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ro_load |-> !(r_out_valid && !i_out_ready))
        else $error("result beat overwritten while held");

    // a divided sample always lands in a regular bin
    a_regular_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix_slot |=> (r_slot != '0) && (r_slot <= r_nb))
        else $error("divided sample outside regular bins");

    // counter updates stay within the bins in use and the overflow bin
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ram_wr |-> (r_slot <= nb_plus1))
        else $error("counter write beyond overflow bin");

    // the store is empty after readout ends
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_valid == '0))
        else $error("counters not cleared after readout");

endmodule

// File: rtl/lbh_ctrl.sv
module lbh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lbh_pkg::t_dp_status  i_status,
    output lbh_pkg::t_dp_cmd     o_cmd
);

    import lbh_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CLASS   = 8'b0000_0010,
        ST_DIV     = 8'b0000_0100,
        ST_FIX     = 8'b0000_1000,
        ST_READ    = 8'b0001_0000,
        ST_WRITE   = 8'b0010_0000,
        ST_RO_RD   = 8'b0100_0000,
        ST_RO_LOAD = 8'b1000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = ST_CLASS;
                end
            end
            ST_CLASS: begin
                cmd.classify = 1'b1;
                n_state      = i_status.bypass ? ST_READ : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix_slot = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                cmd.ram_rd = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.ram_wr = 1'b1;
                n_state    = i_status.item_last ? ST_RO_RD : ST_IDLE;
            end
            ST_RO_RD: begin
                cmd.ro_rd = 1'b1;
                n_state   = ST_RO_LOAD;
            end
            ST_RO_LOAD: begin
                if (!i_status.out_hold) begin
                    cmd.ro_load = 1'b1;
                    if (i_status.ro_end) begin
                        cmd.clear_all = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_state = ST_RO_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: rtl/linear_bin_histogram.sv
// Uniform-bin histogram over signed Q16.16 samples with underflow and overflow
// counters. Each accepted beat is classified against range_min/range_max and,
// when it falls inside the range, its bin is found by a radix-2 restoring
// divider (one quotient bit per cycle) followed by a read-modify-write of a
// saturating 32-bit counter in a RAM with one write and one read port; an
// out-of-range sample skips the divider's 32 steps. A beat with tlast set
// starts readout: the underflow counter, bins 1..bins_in_use and the overflow
// counter leave one beat at a time as the sink allows, tlast marks the
// overflow beat, and all counters read as zero afterwards. A new beat is taken
// only once the previous one is written, never during readout. Counters are
// cleared at reset without any sweep. Write the configuration only while idle.
module linear_bin_histogram (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [lbh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [lbh_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,   // [31:0] sample
    input  logic                               i_s_axis_tlast,   // last_sample
    // histogram stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [lbh_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,   // [4:0] bin_index,
                                                                 // [36:5] bin_count, zero pad
    output logic                               o_m_axis_tlast    // last_bin
);

    import lbh_pkg::*;

    t_dp_cmd             cmd;
    t_dp_status          status;
    logic [SLOT_W-1:0]   bin_index;
    logic [CNT_W-1:0]    bin_count;

    lbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lbh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_s_axis_tdata[DATA_W-1:0]),
        .i_last_sample (i_s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_bin_index   (bin_index),
        .o_bin_count   (bin_count),
        .o_last_bin    (o_m_axis_tlast)
    );

    // pack the result beat
    assign o_m_axis_tdata = {{(OUT_TDATA_W - SLOT_W - CNT_W){1'b0}}, bin_count, bin_index};

endmodule
